>>> design/hlie_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package hlie_pkg;

  // Longest mnemonic part held in the token buffer
  localparam int unsigned TokenChars = 3;
  localparam int unsigned TokW       = 8 * TokenChars;
  localparam int unsigned LenW       = $clog2(TokenChars + 1);
  localparam int unsigned KeyW       = LenW + TokW;
  localparam int unsigned AddrW      = 15;

  // Characters the parser reacts to
  localparam logic [7:0] CharCr    = 8'h0D;
  localparam logic [7:0] CharAt    = 8'h40;
  localparam logic [7:0] CharSlash = 8'h2F;
  localparam logic [7:0] CharEq    = 8'h3D;
  localparam logic [7:0] CharSemi  = 8'h3B;
  localparam logic [7:0] CharMinus = 8'h2D;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;

  // Position within the current line
  typedef enum logic [7:0] {
    PhStart    = 8'b0000_0001,
    PhSlash    = 8'b0000_0010,
    PhFirst    = 8'b0000_0100,
    PhComp     = 8'b0000_1000,
    PhJump     = 8'b0001_0000,
    PhComment  = 8'b0010_0000,
    PhAddr     = 8'b0100_0000,
    PhAddrDone = 8'b1000_0000
  } phase_e;

  typedef struct packed {
    logic [7:0] character;
    logic       end_of_line;
  } in_item_t;

  typedef struct packed {
    logic [15:0] machine_word;
    logic        is_address_form;
    logic        invalid;
  } out_item_t;

  typedef struct packed {
    logic       hit;
    logic [6:0] code;
  } comp_hit_t;

  typedef struct packed {
    logic       hit;
    logic [2:0] code;
  } field_hit_t;

  // comp mnemonic to a-bit plus cccccc
  function automatic comp_hit_t comp_lookup(logic [LenW-1:0] len, logic [TokW-1:0] text);
    comp_hit_t r;
    r.hit = 1'b1;
    case ({len, text})
      {LenW'(0), TokW'(0)}:     r.code = 7'b0101010;
      {LenW'(1), TokW'("0")}:   r.code = 7'b0101010;
      {LenW'(1), TokW'("1")}:   r.code = 7'b0111111;
      {LenW'(2), TokW'("-1")}:  r.code = 7'b0111010;
      {LenW'(1), TokW'("D")}:   r.code = 7'b0001100;
      {LenW'(1), TokW'("A")}:   r.code = 7'b0110000;
      {LenW'(1), TokW'("M")}:   r.code = 7'b1110000;
      {LenW'(2), TokW'("!D")}:  r.code = 7'b0001101;
      {LenW'(2), TokW'("!A")}:  r.code = 7'b0110001;
      {LenW'(2), TokW'("!M")}:  r.code = 7'b1110001;
      {LenW'(2), TokW'("-D")}:  r.code = 7'b0001111;
      {LenW'(2), TokW'("-A")}:  r.code = 7'b0110011;
      {LenW'(2), TokW'("-M")}:  r.code = 7'b1110011;
      {LenW'(3), TokW'("D+1")}: r.code = 7'b0011111;
      {LenW'(3), TokW'("A+1")}: r.code = 7'b0110111;
      {LenW'(3), TokW'("M+1")}: r.code = 7'b1110111;
      {LenW'(3), TokW'("D-1")}: r.code = 7'b0001110;
      {LenW'(3), TokW'("A-1")}: r.code = 7'b0110010;
      {LenW'(3), TokW'("M-1")}: r.code = 7'b1110010;
      {LenW'(3), TokW'("D+A")}: r.code = 7'b0000010;
      {LenW'(3), TokW'("D+M")}: r.code = 7'b1000010;
      {LenW'(3), TokW'("D-A")}: r.code = 7'b0010011;
      {LenW'(3), TokW'("D-M")}: r.code = 7'b1010011;
      {LenW'(3), TokW'("A-D")}: r.code = 7'b0000111;
      {LenW'(3), TokW'("M-D")}: r.code = 7'b1000111;
      {LenW'(3), TokW'("D&A")}: r.code = 7'b0000000;
      {LenW'(3), TokW'("D&M")}: r.code = 7'b1000000;
      {LenW'(3), TokW'("D|A")}: r.code = 7'b0010101;
      {LenW'(3), TokW'("D|M")}: r.code = 7'b1010101;
      default: begin
        r.hit  = 1'b0;
        r.code = 7'b0000000;
      end
    endcase
    return r;
  endfunction

  // dest mnemonic to ddd
  function automatic field_hit_t dest_lookup(logic [LenW-1:0] len, logic [TokW-1:0] text);
    field_hit_t r;
    r.hit = 1'b1;
    case ({len, text})
      {LenW'(0), TokW'(0)}:     r.code = 3'd0;
      {LenW'(1), TokW'("M")}:   r.code = 3'd1;
      {LenW'(1), TokW'("D")}:   r.code = 3'd2;
      {LenW'(2), TokW'("MD")}:  r.code = 3'd3;
      {LenW'(1), TokW'("A")}:   r.code = 3'd4;
      {LenW'(2), TokW'("AM")}:  r.code = 3'd5;
      {LenW'(2), TokW'("AD")}:  r.code = 3'd6;
      {LenW'(3), TokW'("AMD")}: r.code = 3'd7;
      default: begin
        r.hit  = 1'b0;
        r.code = 3'd0;
      end
    endcase
    return r;
  endfunction

  // jump mnemonic to jjj
  function automatic field_hit_t jump_lookup(logic [LenW-1:0] len, logic [TokW-1:0] text);
    field_hit_t r;
    r.hit = 1'b1;
    case ({len, text})
      {LenW'(0), TokW'(0)}:     r.code = 3'd0;
      {LenW'(3), TokW'("JGT")}: r.code = 3'd1;
      {LenW'(3), TokW'("JEQ")}: r.code = 3'd2;
      {LenW'(3), TokW'("JGE")}: r.code = 3'd3;
      {LenW'(3), TokW'("JLT")}: r.code = 3'd4;
      {LenW'(3), TokW'("JNE")}: r.code = 3'd5;
      {LenW'(3), TokW'("JLE")}: r.code = 3'd6;
      {LenW'(3), TokW'("JMP")}: r.code = 3'd7;
      default: begin
        r.hit  = 1'b0;
        r.code = 3'd0;
      end
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

>>> design/hack_line_instruction_encoder.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  Direction  Handshake               Payload
// -------  ---------  ----------------------  ----------------------------------------
// in       sink       in_valid_i / in_stall_o   in_data_i  : character, end_of_line
// out      source     out_valid_o / out_stall_i out_data_o : machine_word, flags
//
// One character is taken per cycle while in_stall_o is low; the parser state
// and the line result are updated in the cycle of the transfer, and the result
// of a line is registered in the output register, or in the skid entry if that one is held.
// Reset puts the parser at line start and empties both output slots.
// A two-entry output (register plus skid) keeps input flowing while a result
// waits; in_stall_o rises only when both entries are occupied.
module hack_line_instruction_encoder (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_stall_o,
  input  hlie_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  wire                 out_stall_i,
  output hlie_pkg::out_item_t out_data_o
);

  // Parser state
  hlie_pkg::phase_e                phase_q, phase_d;
  logic [hlie_pkg::TokW-1:0]       text_q, text_d;
  logic [hlie_pkg::LenW-1:0]       len_q, len_d;
  logic [2:0]                      dest_q, dest_d;
  logic [6:0]                      comp_q, comp_d;
  logic [hlie_pkg::AddrW-1:0]      addr_q, addr_d;
  logic                            neg_q, neg_d;
  logic                            bad_q, bad_d;

  // Output slots
  logic                            out_valid_q, skid_valid_q;
  hlie_pkg::out_item_t             out_q, skid_q;

  logic                            in_xfer, out_xfer, push;
  logic [7:0]                      c;
  logic                            do_first, do_push, do_dest, do_comp;
  hlie_pkg::comp_hit_t             comp_take, comp_fin;
  hlie_pkg::field_hit_t            dest_take, jump_fin;
  logic [3:0]                      digit;
  logic [hlie_pkg::AddrW-1:0]      addr_next;
  logic                            res_valid;
  hlie_pkg::out_item_t             res;
  logic                            fin_bad;
  logic [2:0]                      jump_code;
  logic [6:0]                      comp_word;

  assign c         = in_data_i.character;
  assign in_xfer   = in_valid_i && !in_stall_o;
  assign out_xfer  = out_valid_q && !out_stall_i;
  assign in_stall_o  = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Lookups for a part that closes on this character
  assign comp_take = hlie_pkg::comp_lookup(len_q, text_q);
  assign dest_take = hlie_pkg::dest_lookup(len_q, text_q);

  // Decimal accumulation for address lines
  assign digit     = 4'(c - hlie_pkg::CharZero);
  assign addr_next = hlie_pkg::AddrW'({addr_q, 3'b000} + {addr_q, 1'b0}) +
                     hlie_pkg::AddrW'(digit);

  // Phase decode for one character
  always_comb begin
    phase_d  = phase_q;
    addr_d   = addr_q;
    neg_d    = neg_q;
    do_first = 1'b0;
    do_push  = 1'b0;
    do_dest  = 1'b0;
    do_comp  = 1'b0;
    len_d    = len_q;
    if (c != hlie_pkg::CharCr) begin
      case (phase_q)
        hlie_pkg::PhStart: begin
          if (c == hlie_pkg::CharAt) begin
            phase_d = hlie_pkg::PhAddr;
          end else if (c == hlie_pkg::CharSlash) begin
            phase_d = hlie_pkg::PhSlash;
            do_push = 1'b1;
          end else begin
            phase_d  = hlie_pkg::PhFirst;
            do_first = 1'b1;
          end
        end
        hlie_pkg::PhSlash: begin
          if (c == hlie_pkg::CharSlash) begin
            phase_d = hlie_pkg::PhComment;
          end else begin
            phase_d  = hlie_pkg::PhFirst;
            do_first = 1'b1;
          end
        end
        hlie_pkg::PhFirst: do_first = 1'b1;
        hlie_pkg::PhComp: begin
          if (c == hlie_pkg::CharSemi) begin
            phase_d = hlie_pkg::PhJump;
            do_comp = 1'b1;
          end else begin
            do_push = 1'b1;
          end
        end
        hlie_pkg::PhJump: do_push = 1'b1;
        hlie_pkg::PhAddr: begin
          if (len_q == '0 && c == hlie_pkg::CharMinus) begin
            neg_d = 1'b1;
            len_d = hlie_pkg::LenW'(1);
          end else if (c inside {[hlie_pkg::CharZero:hlie_pkg::CharNine]}) begin
            addr_d = addr_next;
            len_d  = hlie_pkg::LenW'(1);
          end else begin
            phase_d = hlie_pkg::PhAddrDone;
          end
        end
        default: ;
      endcase
    end
    // First part: '=' closes dest, ';' closes comp
    if (do_first) begin
      if (c == hlie_pkg::CharEq) begin
        phase_d = hlie_pkg::PhComp;
        do_dest = 1'b1;
      end else if (c == hlie_pkg::CharSemi) begin
        phase_d = hlie_pkg::PhJump;
        do_comp = 1'b1;
      end else begin
        do_push = 1'b1;
      end
    end
  end

  // Token buffer and part codes
  always_comb begin
    text_d = text_q;
    dest_d = dest_q;
    comp_d = comp_q;
    bad_d  = bad_q;
    if (do_push) begin
      if (len_q < hlie_pkg::LenW'(hlie_pkg::TokenChars)) begin
        text_d = {text_q[hlie_pkg::TokW-9:0], c};
      end else begin
        bad_d = 1'b1;
      end
    end
    if (do_dest) begin
      text_d = '0;
      if (dest_take.hit) dest_d = dest_take.code;
      else bad_d = 1'b1;
    end
    if (do_comp) begin
      text_d = '0;
      if (comp_take.hit) comp_d = comp_take.code;
      else bad_d = 1'b1;
    end
  end

  // Length update kept apart from the address phase use of the counter
  logic [hlie_pkg::LenW-1:0] tok_len_d;
  always_comb begin
    tok_len_d = len_d;
    if (do_push && len_q < hlie_pkg::LenW'(hlie_pkg::TokenChars)) begin
      tok_len_d = len_q + hlie_pkg::LenW'(1);
    end
    if (do_dest || do_comp) begin
      tok_len_d = '0;
    end
  end

  // End-of-line result from the state after this character
  assign comp_fin = hlie_pkg::comp_lookup(tok_len_d, text_d);
  assign jump_fin = hlie_pkg::jump_lookup(tok_len_d, text_d);

  always_comb begin
    res_valid = 1'b1;
    fin_bad   = bad_d;
    jump_code = 3'd0;
    comp_word = comp_d;
    res       = '0;
    case (phase_d)
      hlie_pkg::PhStart, hlie_pkg::PhComment: res_valid = 1'b0;
      hlie_pkg::PhAddr, hlie_pkg::PhAddrDone: ;
      hlie_pkg::PhJump: begin
        jump_code = jump_fin.code;
        if (!jump_fin.hit) fin_bad = 1'b1;
      end
      default: begin
        if (comp_fin.hit) comp_word = comp_fin.code;
        else fin_bad = 1'b1;
      end
    endcase
    if (phase_d inside {hlie_pkg::PhAddr, hlie_pkg::PhAddrDone}) begin
      res.machine_word    = {1'b0, neg_d ? (hlie_pkg::AddrW'(0) - addr_d) : addr_d};
      res.is_address_form = 1'b1;
    end else if (fin_bad) begin
      res.invalid = 1'b1;
    end else begin
      res.machine_word = {3'b111, comp_word, dest_d, jump_code};
    end
  end

  assign push = in_xfer && in_data_i.end_of_line && res_valid;

  // Parser registers: cleared at the end of every line
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= hlie_pkg::PhStart;
      text_q  <= '0;
      len_q   <= '0;
      dest_q  <= '0;
      comp_q  <= '0;
      addr_q  <= '0;
      neg_q   <= 1'b0;
      bad_q   <= 1'b0;
    end else if (in_xfer) begin
      if (in_data_i.end_of_line) begin
        phase_q <= hlie_pkg::PhStart;
        text_q  <= '0;
        len_q   <= '0;
        dest_q  <= '0;
        comp_q  <= '0;
        addr_q  <= '0;
        neg_q   <= 1'b0;
        bad_q   <= 1'b0;
      end else begin
        phase_q <= phase_d;
        text_q  <= text_d;
        len_q   <= tok_len_d;
        dest_q  <= dest_d;
        comp_q  <= comp_d;
        addr_q  <= addr_d;
        neg_q   <= neg_d;
        bad_q   <= bad_d;
      end
    end
  end

  // Output register with skid entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || out_xfer) begin
      out_valid_q  <= skid_valid_q || push;
      skid_valid_q <= 1'b0;
    end else if (push) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || out_xfer) begin
      out_q <= skid_valid_q ? skid_q : res;
    end else if (push) begin
      skid_q <= res;
    end
  end

  // Skid entry is only used behind a full output register
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry occupied while output register empty");

  // A line end always returns the parser to line start
  a_eol_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && in_data_i.end_of_line) |=> (phase_q == hlie_pkg::PhStart && len_q == '0))
    else $error("parser not back at line start after end of line");

  // Token counter never runs past the buffer
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= hlie_pkg::LenW'(hlie_pkg::TokenChars))
    else $error("token length beyond buffer");

  // Invalid results carry a zero word and no address flag
  a_invalid_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.invalid) |->
      (out_data_o.machine_word == '0 && !out_data_o.is_address_form))
    else $error("invalid result with nonzero word or address flag");

  // A full output stage with a stalled consumer blocks further input
  a_full_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i && push) |=> in_stall_o)
    else $error("second pending result did not stall input");

endmodule

`default_nettype wire

>>> tb/tb_hack_line_instruction_encoder.sv
`timescale 1ns / 1ps

module tb_hack_line_instruction_encoder;

  // Tracks the parser state of the line in flight and queues the words it should produce
  class hack_word_tracker;
    string       comp_txt[29];
    logic [5:0]  comp_alu[29];
    string       dest_txt[8];
    string       jump_txt[8];

    hlie_pkg::phase_e ph;
    logic [23:0] tok;
    int unsigned tok_len;
    logic [2:0]  dest;
    logic [6:0]  comp;
    logic [14:0] addr;
    bit          neg;
    bit          bad;

    hlie_pkg::out_item_t expected_words[$];
    int          word_mismatches;

    function new();
      comp_txt = '{"0", "", "1", "-1", "D", "A", "M", "!D", "!A", "!M", "-D", "-A", "-M",
                   "D+1", "A+1", "M+1", "D-1", "A-1", "M-1", "D+A", "D+M", "D-A", "D-M",
                   "A-D", "M-D", "D&A", "D&M", "D|A", "D|M"};
      comp_alu = '{6'h2A, 6'h2A, 6'h3F, 6'h3A, 6'h0C, 6'h30, 6'h30, 6'h0D, 6'h31, 6'h31,
                   6'h0F, 6'h33, 6'h33, 6'h1F, 6'h37, 6'h37, 6'h0E, 6'h32, 6'h32, 6'h02,
                   6'h02, 6'h13, 6'h13, 6'h07, 6'h07, 6'h00, 6'h00, 6'h15, 6'h15};
      dest_txt = '{"", "M", "D", "MD", "A", "AM", "AD", "AMD"};
      jump_txt = '{"", "JGT", "JEQ", "JGE", "JLT", "JNE", "JLE", "JMP"};
      word_mismatches = 0;
      clear_line();
    endfunction

    function void clear_line();
      ph      = hlie_pkg::PhStart;
      tok     = '0;
      tok_len = 0;
      dest    = '0;
      comp    = '0;
      addr    = '0;
      neg     = 1'b0;
      bad     = 1'b0;
    endfunction

    // Appends one word to the pending list
    function void queue_word(hlie_pkg::out_item_t w);
      expected_words = {expected_words, w};
    endfunction

    // True when the buffered token spells s exactly
    function bit tok_is(string s);
      logic [23:0] txt_bits;
      txt_bits = '0;
      for (int i = 0; i < s.len(); i++) txt_bits = {txt_bits[15:0], 8'(s[i])};
      return (s.len() == tok_len) && (txt_bits == tok);
    endfunction

    function void push_tok(logic [7:0] c);
      if (tok_len < hlie_pkg::TokenChars) begin
        tok = {tok[15:0], c};
        tok_len++;
      end else begin
        bad = 1'b1;
      end
    endfunction

    function void take_dest();
      bit hit;
      hit = 1'b0;
      foreach (dest_txt[i]) begin
        if (!hit && tok_is(dest_txt[i])) begin
          dest = 3'(i);
          hit  = 1'b1;
        end
      end
      if (!hit) bad = 1'b1;
      tok     = '0;
      tok_len = 0;
    endfunction

    // a bit comes from any M in the token
    function void take_comp();
      bit hit;
      bit a;
      hit = 1'b0;
      a   = 1'b0;
      for (int i = 0; i < tok_len; i++) begin
        if (tok[8*i +: 8] == "M") a = 1'b1;
      end
      foreach (comp_txt[i]) begin
        if (!hit && tok_is(comp_txt[i])) begin
          comp = {a, comp_alu[i]};
          hit  = 1'b1;
        end
      end
      if (!hit) bad = 1'b1;
      tok     = '0;
      tok_len = 0;
    endfunction

    function void first_part(logic [7:0] c);
      if (c == hlie_pkg::CharEq) begin
        take_dest();
        ph = hlie_pkg::PhComp;
      end else if (c == hlie_pkg::CharSemi) begin
        take_comp();
        ph = hlie_pkg::PhJump;
      end else begin
        push_tok(c);
      end
    endfunction

    function void consume(logic [7:0] c);
      int unsigned acc;
      case (ph)
        hlie_pkg::PhStart: begin
          if (c == hlie_pkg::CharAt) begin
            ph      = hlie_pkg::PhAddr;
            tok_len = 0;
          end else if (c == hlie_pkg::CharSlash) begin
            ph = hlie_pkg::PhSlash;
            push_tok(c);
          end else begin
            ph = hlie_pkg::PhFirst;
            first_part(c);
          end
        end
        hlie_pkg::PhSlash: begin
          if (c == hlie_pkg::CharSlash) begin
            ph = hlie_pkg::PhComment;
          end else begin
            ph = hlie_pkg::PhFirst;
            first_part(c);
          end
        end
        hlie_pkg::PhFirst: first_part(c);
        hlie_pkg::PhComp: begin
          if (c == hlie_pkg::CharSemi) begin
            take_comp();
            ph = hlie_pkg::PhJump;
          end else begin
            push_tok(c);
          end
        end
        hlie_pkg::PhJump: push_tok(c);
        hlie_pkg::PhAddr: begin
          // minus only right after the @, digits accumulate mod 2^15
          if (tok_len == 0 && c == hlie_pkg::CharMinus) begin
            neg     = 1'b1;
            tok_len = 1;
          end else if (c inside {[hlie_pkg::CharZero:hlie_pkg::CharNine]}) begin
            acc     = addr * 10 + (c - hlie_pkg::CharZero);
            addr    = acc[14:0];
            tok_len = 1;
          end else begin
            ph = hlie_pkg::PhAddrDone;
          end
        end
        default: ;
      endcase
    endfunction

    // Called for every input transfer
    function void note_char(hlie_pkg::in_item_t it);
      hlie_pkg::out_item_t w;
      logic [2:0]  jmp;
      logic [14:0] v;
      bit          give;
      bit          hit;
      if (it.character != hlie_pkg::CharCr) consume(it.character);
      if (it.end_of_line) begin
        w    = '0;
        jmp  = '0;
        give = 1'b1;
        case (ph)
          hlie_pkg::PhStart, hlie_pkg::PhComment: give = 1'b0;
          hlie_pkg::PhAddr, hlie_pkg::PhAddrDone: begin
            v = neg ? 15'd0 - addr : addr;
            w.machine_word    = {1'b0, v};
            w.is_address_form = 1'b1;
          end
          default: begin
            if (ph == hlie_pkg::PhJump) begin
              hit = 1'b0;
              foreach (jump_txt[i]) begin
                if (!hit && tok_is(jump_txt[i])) begin
                  jmp = 3'(i);
                  hit = 1'b1;
                end
              end
              if (!hit) bad = 1'b1;
            end else begin
              take_comp();
            end
            if (bad) w.invalid = 1'b1;
            else w.machine_word = {3'b111, comp, dest, jmp};
          end
        endcase
        if (give) queue_word(w);
        clear_line();
      end
    endfunction

    // Called for every output transfer
    function void check_word(hlie_pkg::out_item_t got);
      hlie_pkg::out_item_t want;
      bit        stray;
      stray = (expected_words.size() == 0);
      want  = stray ? '0 : expected_words.pop_front();
      if (stray || got.machine_word !== want.machine_word ||
          got.is_address_form !== want.is_address_form || got.invalid !== want.invalid) begin
        if (word_mismatches < 10)
          $display("word mismatch%s: expected %h addr=%b inv=%b, got %h addr=%b inv=%b",
                   stray ? " (none pending)" : "", want.machine_word, want.is_address_form,
                   want.invalid, got.machine_word, got.is_address_form, got.invalid);
        word_mismatches++;
      end
    endfunction
  endclass

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  hlie_pkg::in_item_t  in_data_i   = '0;
  logic                out_stall_i = 1'b0;
  logic                in_stall_o;
  logic                out_valid_o;
  hlie_pkg::out_item_t out_data_o;

  int send_idle  = 0;
  int recv_stall = 0;

  hack_word_tracker words = new();

  hack_line_instruction_encoder dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always #10 clk_i = ~clk_i;

  // Output side: check each transfer, then pick the next stall
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) words.check_word(out_data_o);
    out_stall_i <= ($urandom_range(99) < recv_stall);
  end

  // One character per transfer, with optional idle cycles before it
  task automatic send_char(input logic [7:0] c, input logic eol);
    hlie_pkg::in_item_t it;
    it.character   = c;
    it.end_of_line = eol;
    while ($urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    words.note_char(it);
  endtask

  task automatic send_line(input logic [7:0] q[$]);
    foreach (q[i]) send_char(q[i], i == q.size() - 1);
  endtask

  // Appends one byte to a line
  function automatic void put_byte(ref logic [7:0] q[$], input logic [7:0] b);
    q = {q, b};
  endfunction

  function automatic void add_text(ref logic [7:0] q[$], input string s);
    for (int i = 0; i < s.len(); i++) put_byte(q, 8'(s[i]));
  endfunction

  task automatic send_text(input string s);
    logic [7:0] q[$];
    add_text(q, s);
    send_line(q);
  endtask

  // Mostly well-formed lines with random content, plus comments and noise
  task automatic gen_line(output logic [7:0] q[$]);
    int    r;
    int    n;
    string junk;
    junk = "=;/@M- ";
    q = {};
    r = $urandom_range(99);
    if (r < 25) begin
      put_byte(q, hlie_pkg::CharAt);
      if ($urandom_range(4) == 0) put_byte(q, hlie_pkg::CharMinus);
      n = $urandom_range(6);
      repeat (n) put_byte(q, 8'(hlie_pkg::CharZero + $urandom_range(9)));
      if ($urandom_range(6) == 0) put_byte(q, 8'($urandom_range(255)));
    end else if (r < 72) begin
      if ($urandom_range(2) != 0) begin
        add_text(q, words.dest_txt[$urandom_range(1, 7)]);
        put_byte(q, hlie_pkg::CharEq);
      end
      add_text(q, words.comp_txt[$urandom_range(28)]);
      if ($urandom_range(1) == 0) begin
        put_byte(q, hlie_pkg::CharSemi);
        add_text(q, words.jump_txt[$urandom_range(7)]);
      end
      // occasional corrupted character
      if ($urandom_range(9) == 0 && q.size() > 0) begin
        n    = $urandom_range(q.size() - 1);
        q[n] = 8'(junk[$urandom_range(junk.len() - 1)]);
      end
    end else if (r < 82) begin
      put_byte(q, hlie_pkg::CharSlash);
      if ($urandom_range(3) != 0) put_byte(q, hlie_pkg::CharSlash);
      n = $urandom_range(4);
      repeat (n) put_byte(q, 8'($urandom_range(255)));
    end else begin
      n = $urandom_range(1, 6);
      repeat (n) put_byte(q, 8'($urandom_range(255)));
    end
    if ($urandom_range(9) == 0) q.insert($urandom_range(q.size()), hlie_pkg::CharCr);
    if (q.size() == 0) put_byte(q, hlie_pkg::CharCr);
  endtask

  initial begin : stimulus
    int         idle_plan[4][2];
    int         phase_chars;
    logic [7:0] line_q[$];
    idle_plan = '{'{0, 0}, '{61, 0}, '{0, 61}, '{13, 13}};

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty and comment lines, address edge cases, bad mnemonics, full C form
    send_text("\015");
    send_text("//");
    send_text("@-1");
    send_text("@99999");
    send_text("@");
    send_text("/D");
    send_text("D=A=1");
    send_text("0;J;M");
    send_text("D+1+");
    send_text(" D");
    send_text("M=\0151");
    send_text("AMD=D|M;JMP");
    send_char(8'hFF, 1'b1);

    // Hold off until every pending word has drained
    in_valid_i <= 1'b0;
    while (words.expected_words.size() != 0) @(posedge clk_i);

    for (int p = 0; p < 4; p++) begin
      send_idle   = idle_plan[p][0];
      recv_stall  = idle_plan[p][1];
      phase_chars = 0;
      while (phase_chars < 300) begin
        gen_line(line_q);
        send_line(line_q);
        phase_chars += line_q.size();
      end
    end

    in_valid_i <= 1'b0;
    while (words.expected_words.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (words.word_mismatches == 0 && words.expected_words.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #3_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

>>> filelist.f
design/hlie_pkg.sv
design/hack_line_instruction_encoder.sv
tb/tb_hack_line_instruction_encoder.sv
